// ===== hdl/p12u_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p12u_pkg
// Shared types and constants for the packed 12-bit pixel unpacker.
// ----------------------------------------------------------------------------
package p12u_pkg;

  // element and pixel widths
  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned CARRY_W = 8;
  localparam int unsigned MAX_PIX = 3;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_FORMAT_MODE = 1'd0;
  localparam cfg_idx_t CFG_KEEP_EIGHT  = 1'd1;

  // format codes
  typedef logic [1:0] fmt_t;
  localparam fmt_t FMT_BYTE   = 2'd0;
  localparam fmt_t FMT_HALF   = 2'd1;
  localparam fmt_t FMT_PACKED = 2'd2;

  // packed-word phase codes
  typedef logic [1:0] phase_t;
  localparam phase_t PHASE_FIRST  = 2'd0;
  localparam phase_t PHASE_SECOND = 2'd1;
  localparam phase_t PHASE_THIRD  = 2'd2;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [PIX_W-1:0] pix_t;

  // packing state carried from word to word
  typedef struct packed {
    phase_t               phase;
    logic [CARRY_W-1:0]   carry;
  } pack_state_t;

  // pixels produced by one element; cnt is 1 to 3
  typedef struct packed {
    pix_t [MAX_PIX-1:0]  pix;
    logic [1:0]          cnt;
  } pix_group_t;

endpackage

// ===== hdl/p12u_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p12u_decode
// Turns one element into its group of pixels and the next packing state.
// ----------------------------------------------------------------------------
module p12u_decode (
  input  p12u_pkg::elem_t       element,
  input  p12u_pkg::fmt_t        format_mode,
  input  logic                  keep_eight_bits,
  input  p12u_pkg::pack_state_t st,
  output p12u_pkg::pix_group_t  grp,
  output p12u_pkg::pack_state_t st_nxt
);
  import p12u_pkg::*;

  logic [7:0] byte_val;

  assign byte_val = element[7:0];

  // per-mode unpacking
  always_comb begin
    grp    = '0;
    st_nxt = st;
    unique case (format_mode)
      FMT_BYTE: begin
        grp.cnt    = 2'd1;
        grp.pix[0] = keep_eight_bits ? {8'h00, byte_val} : {4'h0, byte_val, 4'h0};
      end
      FMT_HALF: begin
        grp.cnt    = 2'd1;
        grp.pix[0] = element[15:0];
      end
      default: begin
        // packed 12-bit, also taken for the unknown format code
        unique case (st.phase)
          PHASE_SECOND: begin
            grp.cnt      = 2'd3;
            grp.pix[0]   = {4'h0, element[3:0], st.carry};
            grp.pix[1]   = {4'h0, element[15:4]};
            grp.pix[2]   = {4'h0, element[27:16]};
            st_nxt.carry = {4'h0, element[31:28]};
            st_nxt.phase = PHASE_THIRD;
          end
          PHASE_THIRD: begin
            grp.cnt      = 2'd3;
            grp.pix[0]   = {4'h0, element[7:0], st.carry[3:0]};
            grp.pix[1]   = {4'h0, element[19:8]};
            grp.pix[2]   = {4'h0, element[31:20]};
            st_nxt.carry = '0;
            st_nxt.phase = PHASE_FIRST;
          end
          default: begin
            // first word; the unreachable phase code acts the same
            grp.cnt      = 2'd2;
            grp.pix[0]   = {4'h0, element[11:0]};
            grp.pix[1]   = {4'h0, element[23:12]};
            st_nxt.carry = element[31:24];
            st_nxt.phase = PHASE_SECOND;
          end
        endcase
      end
    endcase
  end

endmodule

// ===== hdl/p12u_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p12u_serializer
// Holds one pixel group and sends its pixels one per cycle, while out_stall is low,
// through an output register.
// ----------------------------------------------------------------------------
module p12u_serializer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  grp_valid,
  input  p12u_pkg::pix_group_t  grp,
  output logic                  grp_ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output p12u_pkg::pix_t        out_pixel,
  output logic                  out_last
);
  import p12u_pkg::*;

  logic       hold_valid_r, hold_valid_nxt;
  pix_group_t hold_r, hold_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  pix_t       out_pixel_r, out_pixel_nxt;
  logic       out_last_r, out_last_nxt;

  logic       out_free;
  logic       take;
  logic       is_last;

  // output register can load when empty or being drained
  assign out_free  = !out_valid_r || !out_stall;
  assign take      = hold_valid_r && out_free;
  assign is_last   = (idx_r == (hold_r.cnt - 2'd1));
  assign grp_ready = !hold_valid_r || (take && is_last);

  // group holding register and pixel index
  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    idx_nxt        = idx_r;
    if (take) begin
      idx_nxt = idx_r + 2'd1;
      if (is_last) begin
        hold_valid_nxt = 1'b0;
      end
    end
    if (grp_valid && grp_ready) begin
      hold_valid_nxt = 1'b1;
      hold_nxt       = grp;
      idx_nxt        = '0;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pixel_nxt = out_pixel_r;
    out_last_nxt  = out_last_r;
    if (out_free) begin
      out_valid_nxt = take;
      if (take) begin
        out_pixel_nxt = hold_r.pix[idx_r];
        out_last_nxt  = is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
    end
    hold_r      <= hold_nxt;
    out_pixel_r <= out_pixel_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

endmodule

// ===== hdl/packed12_pixel_unpacker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed12_pixel_unpacker_core
// Unpacks bytes, halfwords or packed 12-bit words into 16-bit pixels.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | in_element[31:0]
//  out_    | output    | out_valid/stall   | out_pixel[15:0], out_last
//  cfg_    | input     | cfg_valid/ready   | cfg_index, cfg_data
//
//  One pixel leaves per cycle while out_stall is low: a byte or halfword
//  item gives one pixel, a packed word two or three.
//  An item passes the input, group holding and output registers in turn.
//  Reset clears mode, packing phase and all valid flags.
//  An item is taken while earlier pixels wait; stalls hold each stage.
// ----------------------------------------------------------------------------
module packed12_pixel_unpacker_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  p12u_pkg::elem_t       in_element,
  output logic                  out_valid,
  input  logic                  out_stall,
  output p12u_pkg::pix_t        out_pixel,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  p12u_pkg::cfg_idx_t    cfg_index,
  input  p12u_pkg::cfg_data_t   cfg_data
);
  import p12u_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  elem_t       in_elem_r, in_elem_nxt;
  fmt_t        format_mode_r, format_mode_nxt;
  logic        keep_eight_r, keep_eight_nxt;
  pack_state_t st_r, st_nxt, st_dec;
  pix_group_t  grp;
  logic        grp_ready;
  logic        accept;
  logic        advance;
  logic        cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign advance   = in_valid_r && grp_ready;
  assign in_stall  = in_valid_r && !grp_ready;
  assign accept    = in_valid && !in_stall;

  // input register
  always_comb begin
    in_valid_nxt = in_valid_r;
    in_elem_nxt  = in_elem_r;
    if (advance) begin
      in_valid_nxt = 1'b0;
    end
    if (accept) begin
      in_valid_nxt = 1'b1;
      in_elem_nxt  = in_element;
    end
  end

  p12u_decode u_decode (
    .element         (in_elem_r),
    .format_mode     (format_mode_r),
    .keep_eight_bits (keep_eight_r),
    .st              (st_r),
    .grp             (grp),
    .st_nxt          (st_dec)
  );

  // configuration and packing state
  always_comb begin
    format_mode_nxt = format_mode_r;
    keep_eight_nxt  = keep_eight_r;
    st_nxt          = st_r;
    if (advance) begin
      st_nxt = st_dec;
    end
    if (cfg_wr) begin
      unique case (cfg_index)
        CFG_FORMAT_MODE: begin
          format_mode_nxt = cfg_data;
          st_nxt          = '0;
        end
        CFG_KEEP_EIGHT: begin
          keep_eight_nxt = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      format_mode_r <= FMT_BYTE;
      keep_eight_r  <= 1'b0;
      st_r          <= '0;
    end else begin
      in_valid_r    <= in_valid_nxt;
      format_mode_r <= format_mode_nxt;
      keep_eight_r  <= keep_eight_nxt;
      st_r          <= st_nxt;
    end
    in_elem_r <= in_elem_nxt;
  end

  p12u_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (in_valid_r),
    .grp       (grp),
    .grp_ready (grp_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pixel (out_pixel),
    .out_last  (out_last)
  );

endmodule
